@@ src/pmsc_pkg.sv @@
// Package of the PID motor speed controller: field widths, request codes,
// register indexes, reset values and the structs passed between pipeline stages.
// No dependencies.
package pmsc_pkg;

  // Field widths
  localparam int SPEED_W    = 16;
  localparam int TARGET_W   = 11;
  localparam int ERR_W      = 17;
  localparam int DER_W      = 18;
  localparam int INTEG_W    = 21;
  localparam int ACC_W      = 22;
  localparam int GAIN_W     = 16;
  localparam int ILIM_W     = 20;
  localparam int DUTY_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;
  localparam int P_PROD_W   = GAIN_W + 1 + ERR_W;
  localparam int I_PROD_W   = GAIN_W + 1 + INTEG_W;
  localparam int D_PROD_W   = GAIN_W + 1 + DER_W;
  localparam int SUM_W      = 39;
  localparam int FRAC_W     = 8;

  // Target clamp bounds
  localparam logic signed [SPEED_W-1:0] TARGET_MIN = -16'sd500;
  localparam logic signed [SPEED_W-1:0] TARGET_MAX = 16'sd500;

  // Request codes carried in tuser
  typedef enum logic [1:0] {
    REQ_UPDATE = 2'd0,
    REQ_SET_TARGET = 2'd1,
    REQ_STOP = 2'd2
  } req_t;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEG_LIM = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_LIM  = 3'd4;

  // Register reset values
  localparam logic [GAIN_W-1:0] GAIN_P_RESET    = 16'd256;
  localparam logic [GAIN_W-1:0] GAIN_I_RESET    = 16'd0;
  localparam logic [GAIN_W-1:0] GAIN_D_RESET    = 16'd0;
  localparam logic [ILIM_W-1:0] INTEG_LIM_RESET = 20'd10000;
  localparam logic [DUTY_W-1:0] DUTY_LIM_RESET  = 16'd1000;

  // Controller terms after the state update
  typedef struct packed {
    logic signed [ERR_W-1:0]   err;
    logic signed [INTEG_W-1:0] acc;
    logic signed [DER_W-1:0]   der;
    logic                      reverse;
  } terms_t;

  // Gain products
  typedef struct packed {
    logic signed [P_PROD_W-1:0] p_prod;
    logic signed [I_PROD_W-1:0] i_prod;
    logic signed [D_PROD_W-1:0] d_prod;
    logic                       reverse;
  } products_t;

endpackage

@@ src/pmsc_state.sv @@
// State update stage: target, error integral with clamp, previous error and
// direction; registers the controller terms. Depends on pmsc_pkg.
module pmsc_state (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 item_valid,
  input  logic                                 advance,
  input  pmsc_pkg::req_t                       req,
  input  logic signed [pmsc_pkg::SPEED_W-1:0]  measured_speed,
  input  logic signed [pmsc_pkg::SPEED_W-1:0]  target_request,
  input  logic [pmsc_pkg::ILIM_W-1:0]          integral_limit,
  output logic                                 terms_valid,
  output pmsc_pkg::terms_t                     terms
);

  logic signed [pmsc_pkg::TARGET_W-1:0] target_speed;
  logic signed [pmsc_pkg::TARGET_W-1:0] target_speed_next;
  logic signed [pmsc_pkg::INTEG_W-1:0]  error_integral;
  logic signed [pmsc_pkg::INTEG_W-1:0]  error_integral_next;
  logic signed [pmsc_pkg::ERR_W-1:0]    last_error;
  logic signed [pmsc_pkg::ERR_W-1:0]    last_error_next;
  logic                                 last_direction;
  logic                                 last_direction_next;
  logic                                 terms_valid_next;
  pmsc_pkg::terms_t                     terms_next;

  logic signed [pmsc_pkg::ERR_W-1:0]    err;
  logic signed [pmsc_pkg::ACC_W-1:0]    acc_raw;
  logic signed [pmsc_pkg::ACC_W-1:0]    lim_pos;
  logic signed [pmsc_pkg::ACC_W-1:0]    lim_neg;
  logic signed [pmsc_pkg::ACC_W-1:0]    acc_clamped;
  logic signed [pmsc_pkg::DER_W-1:0]    der;
  logic signed [pmsc_pkg::TARGET_W-1:0] target_clamped;
  logic                                 take;

  assign take = item_valid && advance;

  // Error, integral with symmetric clamp, derivative
  always_comb begin
    err = pmsc_pkg::ERR_W'(target_speed) - pmsc_pkg::ERR_W'(measured_speed);
    acc_raw = pmsc_pkg::ACC_W'(error_integral) + pmsc_pkg::ACC_W'(err);
    lim_pos = $signed({2'b00, integral_limit});
    lim_neg = -lim_pos;
    priority if (acc_raw > lim_pos) begin
      acc_clamped = lim_pos;
    end else if (acc_raw < lim_neg) begin
      acc_clamped = lim_neg;
    end else begin
      acc_clamped = acc_raw;
    end
    der = pmsc_pkg::DER_W'(err) - pmsc_pkg::DER_W'(last_error);
  end

  // Clamp a requested target into range
  always_comb begin
    priority if (target_request < pmsc_pkg::TARGET_MIN) begin
      target_clamped = pmsc_pkg::TARGET_W'(pmsc_pkg::TARGET_MIN);
    end else if (target_request > pmsc_pkg::TARGET_MAX) begin
      target_clamped = pmsc_pkg::TARGET_W'(pmsc_pkg::TARGET_MAX);
    end else begin
      target_clamped = target_request[pmsc_pkg::TARGET_W-1:0];
    end
  end

  // Decode the request into next state and terms
  always_comb begin
    target_speed_next   = target_speed;
    error_integral_next = error_integral;
    last_error_next     = last_error;
    last_direction_next = last_direction;
    terms_valid_next    = 1'b0;
    terms_next.err      = '0;
    terms_next.acc      = '0;
    terms_next.der      = '0;
    terms_next.reverse  = last_direction;
    if (take) begin
      unique case (req)
        pmsc_pkg::REQ_UPDATE: begin
          error_integral_next = acc_clamped[pmsc_pkg::INTEG_W-1:0];
          last_error_next     = err;
          last_direction_next = target_speed[pmsc_pkg::TARGET_W-1];
          terms_valid_next    = 1'b1;
          terms_next.err      = err;
          terms_next.acc      = acc_clamped[pmsc_pkg::INTEG_W-1:0];
          terms_next.der      = der;
          terms_next.reverse  = target_speed[pmsc_pkg::TARGET_W-1];
        end
        pmsc_pkg::REQ_SET_TARGET: begin
          target_speed_next = target_clamped;
        end
        pmsc_pkg::REQ_STOP: begin
          // Clear the loop state; duty comes out as zero
          target_speed_next   = '0;
          error_integral_next = '0;
          last_error_next     = '0;
          terms_valid_next    = 1'b1;
        end
        default: begin
          // Drop the unused request code
        end
      endcase
    end
  end

  // Hold state and terms
  always_ff @(posedge clk) begin
    if (rst) begin
      target_speed   <= '0;
      error_integral <= '0;
      last_error     <= '0;
      last_direction <= 1'b0;
      terms_valid    <= 1'b0;
    end else begin
      target_speed   <= target_speed_next;
      error_integral <= error_integral_next;
      last_error     <= last_error_next;
      last_direction <= last_direction_next;
      if (advance) begin
        terms_valid <= terms_valid_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      terms <= terms_next;
    end
  end

endmodule

@@ src/pmsc_mult.sv @@
// Gain multiply stage: three signed products of the gains and controller terms,
// registered. Depends on pmsc_pkg.
module pmsc_mult (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          terms_valid,
  input  logic                          advance,
  input  pmsc_pkg::terms_t              terms,
  input  logic [pmsc_pkg::GAIN_W-1:0]   gain_p,
  input  logic [pmsc_pkg::GAIN_W-1:0]   gain_i,
  input  logic [pmsc_pkg::GAIN_W-1:0]   gain_d,
  output logic                          products_valid,
  output pmsc_pkg::products_t           products
);

  pmsc_pkg::products_t products_next;

  // Multiply each term by its unsigned gain, both widened to the product width
  always_comb begin
    products_next.p_prod  = pmsc_pkg::P_PROD_W'($signed({1'b0, gain_p}))
                          * pmsc_pkg::P_PROD_W'(terms.err);
    products_next.i_prod  = pmsc_pkg::I_PROD_W'($signed({1'b0, gain_i}))
                          * pmsc_pkg::I_PROD_W'(terms.acc);
    products_next.d_prod  = pmsc_pkg::D_PROD_W'($signed({1'b0, gain_d}))
                          * pmsc_pkg::D_PROD_W'(terms.der);
    products_next.reverse = terms.reverse;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      products_valid <= 1'b0;
    end else if (advance) begin
      products_valid <= terms_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      products <= products_next;
    end
  end

endmodule

@@ src/pmsc_out.sv @@
// Output stage: sums the products, takes the magnitude, drops the Q8.8
// fraction and saturates to the duty limit. Depends on pmsc_pkg.
module pmsc_out (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          products_valid,
  input  logic                          advance,
  input  pmsc_pkg::products_t           products,
  input  logic [pmsc_pkg::DUTY_W-1:0]   duty_limit,
  output logic                          result_valid,
  output logic [pmsc_pkg::DUTY_W-1:0]   pwm_duty,
  output logic                          reverse
);

  localparam int MAG_W = pmsc_pkg::SUM_W - pmsc_pkg::FRAC_W;

  logic signed [pmsc_pkg::SUM_W-1:0] sum;
  logic [pmsc_pkg::SUM_W-1:0]        mag;
  logic [MAG_W-1:0]                  mag_int;
  logic [pmsc_pkg::DUTY_W-1:0]       pwm_duty_next;

  // Sum, magnitude, truncate and saturate
  always_comb begin
    sum = pmsc_pkg::SUM_W'(products.p_prod) + pmsc_pkg::SUM_W'(products.i_prod)
        + pmsc_pkg::SUM_W'(products.d_prod);
    mag = sum[pmsc_pkg::SUM_W-1] ? pmsc_pkg::SUM_W'(-sum) : pmsc_pkg::SUM_W'(sum);
    mag_int = mag[pmsc_pkg::SUM_W-1:pmsc_pkg::FRAC_W];
    if (mag_int > MAG_W'(duty_limit)) begin
      pwm_duty_next = duty_limit;
    end else begin
      pwm_duty_next = mag_int[pmsc_pkg::DUTY_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= products_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pwm_duty <= pwm_duty_next;
      reverse  <= products.reverse;
    end
  end

endmodule

@@ src/pid_motor_speed_controller.sv @@
// Top level of the PID motor speed controller: stream ports, configuration
// registers, input register and pipeline flow control.
// Depends on pmsc_pkg, pmsc_state, pmsc_mult and pmsc_out.

// Discrete PID speed regulator in a four-register pipeline: input register,
// state update (error, clamped integral, derivative), gain multiply, then sum,
// magnitude, Q8.8 truncation and duty saturation into the output register. It
// takes one transaction per cycle while s_tready is high; an update or emergency stop passes through
// the terms, product and output registers to its result, and each stage holds an item independently, so
// the input keeps accepting while the output waits as long as a bubble remains.
// A set-target transaction and the unused request code give no result. The loop
// state lives only in the update stage, so items follow each other back to back.
// The user must write configuration with no transaction in flight; the block does not enforce this.
module pid_motor_speed_controller (
  input  logic                               clk,
  input  logic                               rst,
  // Input stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [31:0]                        s_tdata,  // measured_speed[15:0], target_request[31:16]
  input  logic [1:0]                         s_tuser,  // req_type[1:0]
  // Result stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [23:0]                        m_tdata,  // pwm_duty[15:0], reverse[16], zero[23:17]
  // Configuration write port
  input  logic                               cfg_wr_en,
  input  logic [pmsc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pmsc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic [pmsc_pkg::GAIN_W-1:0] gain_p;
  logic [pmsc_pkg::GAIN_W-1:0] gain_i;
  logic [pmsc_pkg::GAIN_W-1:0] gain_d;
  logic [pmsc_pkg::ILIM_W-1:0] integral_limit;
  logic [pmsc_pkg::DUTY_W-1:0] duty_limit;

  logic                                  in_valid;
  pmsc_pkg::req_t                        in_req;
  logic signed [pmsc_pkg::SPEED_W-1:0]   in_measured;
  logic signed [pmsc_pkg::SPEED_W-1:0]   in_target;

  logic                 terms_valid;
  pmsc_pkg::terms_t     terms;
  logic                 products_valid;
  pmsc_pkg::products_t  products;
  logic [pmsc_pkg::DUTY_W-1:0] pwm_duty;
  logic                 reverse;

  logic en_out;
  logic en_mult;
  logic en_state;
  logic en_in;

  // Advance each stage when the one after it is empty or advancing
  assign en_out   = !m_tvalid || m_tready;
  assign en_mult  = !products_valid || en_out;
  assign en_state = !terms_valid || en_mult;
  assign en_in    = !in_valid || en_state;
  assign s_tready = en_in;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p         <= pmsc_pkg::GAIN_P_RESET;
      gain_i         <= pmsc_pkg::GAIN_I_RESET;
      gain_d         <= pmsc_pkg::GAIN_D_RESET;
      integral_limit <= pmsc_pkg::INTEG_LIM_RESET;
      duty_limit     <= pmsc_pkg::DUTY_LIM_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        pmsc_pkg::CFG_GAIN_P:    gain_p         <= cfg_data[pmsc_pkg::GAIN_W-1:0];
        pmsc_pkg::CFG_GAIN_I:    gain_i         <= cfg_data[pmsc_pkg::GAIN_W-1:0];
        pmsc_pkg::CFG_GAIN_D:    gain_d         <= cfg_data[pmsc_pkg::GAIN_W-1:0];
        pmsc_pkg::CFG_INTEG_LIM: integral_limit <= cfg_data[pmsc_pkg::ILIM_W-1:0];
        pmsc_pkg::CFG_DUTY_LIM:  duty_limit     <= cfg_data[pmsc_pkg::DUTY_W-1:0];
        default: begin
          // Ignore writes beyond the register list
        end
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (en_in) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_in) begin
      in_req      <= pmsc_pkg::req_t'(s_tuser);
      in_measured <= $signed(s_tdata[15:0]);
      in_target   <= $signed(s_tdata[31:16]);
    end
  end

  pmsc_state u_state (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (in_valid),
    .advance        (en_state),
    .req            (in_req),
    .measured_speed (in_measured),
    .target_request (in_target),
    .integral_limit (integral_limit),
    .terms_valid    (terms_valid),
    .terms          (terms)
  );

  pmsc_mult u_mult (
    .clk            (clk),
    .rst            (rst),
    .terms_valid    (terms_valid),
    .advance        (en_mult),
    .terms          (terms),
    .gain_p         (gain_p),
    .gain_i         (gain_i),
    .gain_d         (gain_d),
    .products_valid (products_valid),
    .products       (products)
  );

  pmsc_out u_out (
    .clk            (clk),
    .rst            (rst),
    .products_valid (products_valid),
    .advance        (en_out),
    .products       (products),
    .duty_limit     (duty_limit),
    .result_valid   (m_tvalid),
    .pwm_duty       (pwm_duty),
    .reverse        (reverse)
  );

  assign m_tdata = {7'd0, reverse, pwm_duty};

  // Duty never exceeds the configured limit
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[15:0] <= duty_limit))
    else $error("pwm duty above duty limit");

  // Input stalls only when every stage holds an item and the output waits
  assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (in_valid && terms_valid && products_valid && m_tvalid && !m_tready))
    else $error("input stalled with a free stage");

  // No result straight after reset
  assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result valid after reset");

endmodule

@@ tb/pmsc_duty_checker.sv @@
// Checker for the PID motor speed controller: watches the input, result and
// configuration channels, predicts each result and compares it field by field.
// Depends on pmsc_pkg.
module pmsc_duty_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [31:0]                     s_tdata,   // measured_speed[15:0], target_request[31:16]
  input  logic [1:0]                      s_tuser,   // req_type[1:0]
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [23:0]                     m_tdata,   // pwm_duty[15:0], reverse[16], zero[23:17]
  input  logic                            cfg_wr_en,
  input  logic [pmsc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pmsc_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              fail_count,
  output int                              pending_results
);

  typedef struct {
    logic [pmsc_pkg::DUTY_W-1:0] duty;
    logic                        reverse;
  } motor_cmd_t;

  motor_cmd_t expected_cmds[$];

  // Register mirror
  logic [pmsc_pkg::GAIN_W-1:0] kp, ki, kd;
  logic [pmsc_pkg::ILIM_W-1:0] integ_limit;
  logic [pmsc_pkg::DUTY_W-1:0] duty_limit;

  // Loop state mirror
  logic signed [pmsc_pkg::TARGET_W-1:0] target;
  logic signed [pmsc_pkg::INTEG_W-1:0]  integral;
  logic signed [pmsc_pkg::ERR_W-1:0]    prev_err;
  logic                                 reverse_dir;

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    fail_count++;
  endtask

  // Mirror the block at every edge: registers, then results, then requests
  always @(posedge clk) begin : pid_predict
    logic signed [pmsc_pkg::SPEED_W-1:0] meas;
    logic signed [pmsc_pkg::SPEED_W-1:0] treq;
    logic signed [pmsc_pkg::ERR_W-1:0]   err;
    logic signed [pmsc_pkg::ACC_W-1:0]   acc;
    logic signed [pmsc_pkg::ACC_W-1:0]   lim;
    logic signed [pmsc_pkg::DER_W-1:0]   der;
    longint                              sum;
    longint                              mag;
    motor_cmd_t                          got;
    motor_cmd_t                          want;
    if (rst) begin
      kp          = pmsc_pkg::GAIN_P_RESET;
      ki          = pmsc_pkg::GAIN_I_RESET;
      kd          = pmsc_pkg::GAIN_D_RESET;
      integ_limit = pmsc_pkg::INTEG_LIM_RESET;
      duty_limit  = pmsc_pkg::DUTY_LIM_RESET;
      target      = '0;
      integral    = '0;
      prev_err    = '0;
      reverse_dir = 1'b0;
      fail_count  = 0;
      expected_cmds.delete();
    end else begin
      // Register writes
      if (cfg_wr_en) begin
        case (cfg_index)
          pmsc_pkg::CFG_GAIN_P:    kp = cfg_data[pmsc_pkg::GAIN_W-1:0];
          pmsc_pkg::CFG_GAIN_I:    ki = cfg_data[pmsc_pkg::GAIN_W-1:0];
          pmsc_pkg::CFG_GAIN_D:    kd = cfg_data[pmsc_pkg::GAIN_W-1:0];
          pmsc_pkg::CFG_INTEG_LIM: integ_limit = cfg_data[pmsc_pkg::ILIM_W-1:0];
          pmsc_pkg::CFG_DUTY_LIM:  duty_limit = cfg_data[pmsc_pkg::DUTY_W-1:0];
          default: ;
        endcase
      end

      // Compare a result transaction with the oldest expectation
      if (m_tvalid && m_tready) begin
        got.duty    = m_tdata[pmsc_pkg::DUTY_W-1:0];
        got.reverse = m_tdata[pmsc_pkg::DUTY_W];
        if (expected_cmds.size() == 0) begin
          report_mismatch($sformatf("result duty %0d reverse %0d with nothing expected",
                                    got.duty, got.reverse));
        end else begin
          want = expected_cmds.pop_front();
          if (got.duty !== want.duty)
            report_mismatch($sformatf("pwm_duty got %0d expected %0d", got.duty, want.duty));
          if (got.reverse !== want.reverse)
            report_mismatch($sformatf("reverse got %0d expected %0d",
                                      got.reverse, want.reverse));
        end
      end

      // Advance the loop state on an input transaction
      if (s_tvalid && s_tready) begin
        meas = s_tdata[15:0];
        treq = s_tdata[31:16];
        case (s_tuser)
          pmsc_pkg::REQ_SET_TARGET: begin
            if (treq < pmsc_pkg::TARGET_MIN)
              target = pmsc_pkg::TARGET_MIN[pmsc_pkg::TARGET_W-1:0];
            else if (treq > pmsc_pkg::TARGET_MAX)
              target = pmsc_pkg::TARGET_MAX[pmsc_pkg::TARGET_W-1:0];
            else
              target = treq[pmsc_pkg::TARGET_W-1:0];
          end
          pmsc_pkg::REQ_STOP: begin
            // Clear the loop; the direction of the latest update is kept
            target   = '0;
            integral = '0;
            prev_err = '0;
            expected_cmds.push_back('{duty: '0, reverse: reverse_dir});
          end
          pmsc_pkg::REQ_UPDATE: begin
            err = pmsc_pkg::ERR_W'(target) - pmsc_pkg::ERR_W'(meas);
            acc = pmsc_pkg::ACC_W'(integral) + pmsc_pkg::ACC_W'(err);
            lim = $signed({2'b00, integ_limit});
            if (acc > lim)
              acc = lim;
            if (acc < -lim)
              acc = -lim;
            integral = acc[pmsc_pkg::INTEG_W-1:0];
            der      = pmsc_pkg::DER_W'(err) - pmsc_pkg::DER_W'(prev_err);
            prev_err = err;
            sum = longint'(kp) * longint'(err)
                + longint'(ki) * longint'(integral)
                + longint'(kd) * longint'(der);
            mag = (sum < 0 ? -sum : sum) >> pmsc_pkg::FRAC_W;
            if (mag > longint'(duty_limit))
              mag = longint'(duty_limit);
            reverse_dir = (target < 0);
            expected_cmds.push_back('{duty: mag[pmsc_pkg::DUTY_W-1:0], reverse: reverse_dir});
          end
          default: ;  // unused request code: no effect
        endcase
      end
    end
    pending_results = expected_cmds.size();
  end

endmodule

@@ tb/tb_pid_motor_speed_controller.sv @@
// Testbench top of the PID motor speed controller: clock, reset, stimulus,
// receiver back-pressure, watchdog and verdict.
// Depends on pmsc_pkg, pid_motor_speed_controller and pmsc_duty_checker.
module tb_pid_motor_speed_controller;

  localparam logic [1:0] REQ_UNUSED   = 2'd3;
  localparam int         IDLE_LIMIT   = 5000;
  localparam int         HOLD_CYCLES  = 200;
  localparam int         SETTLE       = 12;
  localparam int         PHASES       = 8;
  localparam int         PHASE_ITEMS  = 188;
  localparam int         PRESSURE_LEN = 30;

  logic                            clk       = 1'b0;
  logic                            rst       = 1'b1;
  logic                            s_tvalid  = 1'b0;
  logic                            s_tready;
  logic [31:0]                     s_tdata   = '0;
  logic [1:0]                      s_tuser   = pmsc_pkg::REQ_UPDATE;
  logic                            m_tvalid;
  logic                            m_tready  = 1'b0;
  logic [23:0]                     m_tdata;
  logic                            cfg_wr_en = 1'b0;
  logic [pmsc_pkg::CFG_IDX_W-1:0]  cfg_index = pmsc_pkg::CFG_GAIN_P;
  logic [pmsc_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  int   chk_fail_count;
  int   chk_pending;
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  logic hold_req       = 1'b0;
  logic hold_seen      = 1'b0;
  int   hold_left      = 0;
  int   quiet_cycles   = 0;

  always #4 clk = ~clk;

  pid_motor_speed_controller dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pmsc_duty_checker duty_chk (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tuser         (s_tuser),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (chk_fail_count),
    .pending_results (chk_pending)
  );

  // Receiver: random stalls, or a long hold-off when one is requested
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("FAIL pid_motor_speed_controller");
      $finish;
    end
  end

  // Offer one item after a random gap and hold it until accepted
  task automatic send_item(input logic [1:0] kind, input logic [15:0] meas,
                           input logic [15:0] treq);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {treq, meas};
    @(posedge clk);
    while (!s_tready)
      @(posedge clk);
    @(negedge clk);
  endtask

  // Stop offering and wait until every result is back and the pipe is empty
  task automatic drain();
    s_tvalid <= 1'b0;
    while (chk_pending != 0)
      @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [pmsc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [pmsc_pkg::CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic write_config(input logic [15:0] p, input logic [15:0] i, input logic [15:0] d,
                              input logic [19:0] ilim, input logic [15:0] dlim);
    write_reg(pmsc_pkg::CFG_GAIN_P, pmsc_pkg::CFG_DATA_W'(p));
    write_reg(pmsc_pkg::CFG_GAIN_I, pmsc_pkg::CFG_DATA_W'(i));
    write_reg(pmsc_pkg::CFG_GAIN_D, pmsc_pkg::CFG_DATA_W'(d));
    write_reg(pmsc_pkg::CFG_INTEG_LIM, ilim);
    write_reg(pmsc_pkg::CFG_DUTY_LIM, pmsc_pkg::CFG_DATA_W'(dlim));
  endtask

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom);
      default: return 16'($urandom_range(0, 600));
    endcase
  endfunction

  // Mostly speeds near the target range, sometimes anything at all
  function automatic logic [15:0] pick_speed();
    int v;
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'($urandom);
      default: begin
        v = $urandom_range(0, 1400);
        return 16'(v - 700);
      end
    endcase
  endfunction

  task automatic send_random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 64)
      send_item(pmsc_pkg::REQ_UPDATE, pick_speed(), 16'($urandom));
    else if (r < 82)
      send_item(pmsc_pkg::REQ_SET_TARGET, 16'($urandom), pick_speed());
    else if (r < 90)
      send_item(pmsc_pkg::REQ_STOP, 16'($urandom), 16'($urandom));
    else if (r < 94)
      send_item(REQ_UNUSED, 16'($urandom), 16'($urandom));
    else
      send_item(pmsc_pkg::REQ_UPDATE, 16'($urandom), 16'($urandom));
  endtask

  initial begin : stimulus
    logic [19:0] ilim;
    logic [15:0] dlim;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: reset settings, field extremes, target clamp, stop, unused code
    send_item(pmsc_pkg::REQ_UPDATE, 16'd0, 16'd0);
    send_item(pmsc_pkg::REQ_UPDATE, 16'h8000, 16'hFFFF);
    send_item(pmsc_pkg::REQ_UPDATE, 16'h7FFF, 16'h0000);
    send_item(pmsc_pkg::REQ_SET_TARGET, 16'hFFFF, 16'h7FFF);
    send_item(pmsc_pkg::REQ_UPDATE, 16'h8000, 16'h0000);
    send_item(pmsc_pkg::REQ_SET_TARGET, 16'h0000, 16'h8000);
    send_item(pmsc_pkg::REQ_UPDATE, 16'h7FFF, 16'hFFFF);
    send_item(pmsc_pkg::REQ_STOP, 16'h1234, 16'h4321);
    send_item(REQ_UNUSED, 16'hFFFF, 16'hFFFF);
    send_item(pmsc_pkg::REQ_UPDATE, 16'd0, 16'd0);
    send_item(pmsc_pkg::REQ_SET_TARGET, 16'd0, 16'd501);
    send_item(pmsc_pkg::REQ_SET_TARGET, 16'd0, -16'sd501);
    send_item(pmsc_pkg::REQ_UPDATE, 16'd100, 16'd0);

    // Directed: all registers at their maximum, target at the clamp bound, extreme speeds
    drain();
    write_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 20'hFFFFF, 16'hFFFF);
    send_item(pmsc_pkg::REQ_SET_TARGET, 16'd0, 16'd500);
    send_item(pmsc_pkg::REQ_UPDATE, 16'h8000, 16'd0);
    send_item(pmsc_pkg::REQ_UPDATE, 16'h8000, 16'd0);
    send_item(pmsc_pkg::REQ_UPDATE, 16'h7FFF, 16'd0);

    // Directed: lower the integral limit below the stored integral
    drain();
    write_reg(pmsc_pkg::CFG_INTEG_LIM, 20'd0);
    send_item(pmsc_pkg::REQ_UPDATE, 16'd0, 16'd0);
    send_item(pmsc_pkg::REQ_UPDATE, 16'd7, 16'd0);
    send_item(pmsc_pkg::REQ_STOP, 16'd0, 16'd0);

    // Pressure: hold the receiver off while items keep coming
    drain();
    write_config(16'd256, 16'd16, 16'd64, 20'd10000, 16'd2000);
    send_idle_pct = 0;
    hold_req <= ~hold_req;
    repeat (PRESSURE_LEN) send_random_item();

    // Random phases, each with fresh settings and its own idling pattern
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      case ($urandom_range(0, 3))
        0:       ilim = '0;
        1:       ilim = 20'hFFFFF;
        2:       ilim = 20'($urandom);
        default: ilim = 20'($urandom_range(0, 5000));
      endcase
      case ($urandom_range(0, 4))
        0:       dlim = '0;
        1:       dlim = 16'hFFFF;
        2:       dlim = 16'($urandom);
        default: dlim = 16'($urandom_range(100, 4000));
      endcase
      write_config(pick_gain(), pick_gain(), pick_gain(), ilim, dlim);
      case (ph % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct <= 0;
        end
        1: begin
          send_idle_pct = 69;
          recv_stall_pct <= 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct <= 69;
        end
        default: begin
          send_idle_pct = 31;
          recv_stall_pct <= 31;
        end
      endcase
      repeat (PHASE_ITEMS) send_random_item();
    end

    drain();
    if (chk_fail_count == 0 && chk_pending == 0)
      $display("PASS pid_motor_speed_controller");
    else
      $display("FAIL pid_motor_speed_controller");
    $finish;
  end

endmodule

@@ files.f @@
src/pmsc_pkg.sv
src/pmsc_state.sv
src/pmsc_mult.sv
src/pmsc_out.sv
src/pid_motor_speed_controller.sv
tb/pmsc_duty_checker.sv
tb/tb_pid_motor_speed_controller.sv
